FILE: rtl/fat_short_name_directory_lookup_top_assert.svh
// assertion macros shared by the lookup rtl
`ifndef FAT_SHORT_NAME_DIRECTORY_LOOKUP_TOP_ASSERT_SVH
`define FAT_SHORT_NAME_DIRECTORY_LOOKUP_TOP_ASSERT_SVH

// property checked on every clock edge outside reset
`define FDL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define FDL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/fdl_pkg.sv
package fdl_pkg;

  // name geometry
  localparam int NAME_LEN = 11;
  localparam int EXT_POS  = 8;

  // opcodes carried in the input tuser
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_CHAR  = 2'd1;
  localparam logic [1:0] OP_ENTRY = 2'd2;

  // status codes carried in the output tuser
  localparam logic [1:0] ST_NONE      = 2'd0;
  localparam logic [1:0] ST_MATCH     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FINISHED  = 2'd3;

  // special byte values
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] MARK_DEL   = 8'he5;
  localparam logic [7:0] MARK_E5    = 8'h05;

  // attribute bits
  localparam int ATTR_VOLUME = 3;
  localparam int ATTR_DIR    = 4;

  typedef logic [NAME_LEN-1:0][7:0] name_t;

  // decoded transaction kind
  typedef struct packed {
    logic start_op;
    logic char_op;
    logic entry_op;
  } ctl_t;

  // one result item
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic [7:0] index;
  } res_t;

endpackage

FILE: rtl/fdl_name_build.sv
module fdl_name_build (
  input  logic           clk,
  input  logic           rst,
  input  fdl_pkg::ctl_t  ctl,
  input  logic [7:0]     path_char,
  output fdl_pkg::name_t name
);
  import fdl_pkg::*;

  logic [3:0] write_pos;
  logic [3:0] chars_taken;
  logic       name_closed;
  logic [7:0] upper_char;
  logic [3:0] chars_next;

  // case folding and character count
  assign upper_char = (path_char >= CH_LOWER_A && path_char <= CH_LOWER_Z) ?
                      (path_char - 8'h20) : path_char;
  assign chars_next = chars_taken + 4'd1;

  // name assembly
  always_ff @(posedge clk) begin
    if (rst || ctl.start_op) begin
      name        <= {NAME_LEN{CH_SPACE}};
      write_pos   <= '0;
      chars_taken <= '0;
      name_closed <= 1'b0;
    end else if (ctl.char_op && !name_closed) begin
      if (write_pos >= 4'(NAME_LEN) || path_char == CH_NUL) begin
        name_closed <= 1'b1;
      end else begin
        if (path_char == CH_DOT) begin
          write_pos <= 4'(EXT_POS);
        end else begin
          name[write_pos] <= upper_char;
          write_pos       <= write_pos + 4'd1;
        end
        chars_taken <= chars_next;
        if (chars_next >= 4'(NAME_LEN)) begin
          name_closed <= 1'b1;
        end
      end
    end else if (ctl.entry_op) begin
      name_closed <= 1'b1;
    end
  end

endmodule

FILE: rtl/fdl_lane.sv
module fdl_lane (
  input  logic [7:0] entry_byte,
  input  logic [7:0] name_byte,
  output logic       equal
);

  // one byte position of the name compare
  assign equal = (entry_byte == name_byte);

endmodule

FILE: rtl/fdl_merge.sv
module fdl_merge #(
  parameter int ROOT_ENTRIES = 224
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fdl_pkg::ctl_t                 ctl,
  input  logic [fdl_pkg::NAME_LEN-1:0]  lane_eq,
  input  logic [7:0]                    first_byte,
  input  logic [7:0]                    attribute,
  output fdl_pkg::res_t                 res
);
  import fdl_pkg::*;

  logic [7:0] entry_count;
  logic       search_done;
  logic [8:0] count_ext;
  logic       usable;

  assign count_ext = {1'b0, entry_count};

  // entry is a live file whose name may match
  assign usable = first_byte != MARK_DEL && first_byte != MARK_E5 &&
                  !attribute[ATTR_VOLUME] && !attribute[ATTR_DIR];

  // combine the lane results into a status
  always_comb begin
    res.valid  = ctl.entry_op;
    res.index  = entry_count;
    res.status = ST_NONE;
    priority if (search_done) begin
      res.status = ST_FINISHED;
    end else if (first_byte == CH_NUL) begin
      res.status = ST_NOT_FOUND;
    end else if (usable && (&lane_eq)) begin
      res.status = ST_MATCH;
    end else if (count_ext + 9'd1 >= 9'(ROOT_ENTRIES)) begin
      res.status = ST_NOT_FOUND;
    end else begin
      res.status = ST_NONE;
    end
  end

  // search progress
  always_ff @(posedge clk) begin
    if (rst || ctl.start_op) begin
      entry_count <= '0;
      search_done <= 1'b0;
    end else if (ctl.entry_op && !search_done) begin
      if (res.status == ST_NONE) begin
        entry_count <= entry_count + 8'd1;
      end else begin
        search_done <= 1'b1;
      end
    end
  end

  `include "fat_short_name_directory_lookup_top_assert.svh"

  `FDL_ASSERT(a_done_holds, search_done && !ctl.start_op |=> search_done, "search reopened")
  `FDL_ASSERT(a_count_range, count_ext < 9'(ROOT_ENTRIES), "entry count out of range")
  `FDL_ASSERT(a_end_sets_done, res.valid && (res.status == ST_MATCH || res.status == ST_NOT_FOUND) |=> search_done, "search end not recorded")

endmodule

FILE: rtl/fat_short_name_directory_lookup_top.sv
// FAT 8.3 short name lookup in a root directory.
// Input stream s_*: tuser carries the opcode (start, path character, entry),
// tdata the path character and the entry name bytes and attribute.
// A start clears the lookup, path characters build the 11-byte name, then
// directory entries are offered one per transaction; each entry yields one
// result on m_*: tuser is the status, tdata the index of the entry.
// Start and path character transactions produce no result.
// Throughput: one input transaction per cycle while s_tready is high, set by
// the 11 byte-compare lanes and merge logic that resolve an entry combinationally.
// Latency: a result appears on m_tvalid the cycle after its entry is
// accepted when the output is free.
// The output register is backed by a one-entry skid stage; when the receiver
// stalls, input is still taken until the skid stage fills, then s_tready
// drops until the receiver takes a result.
// Reset (rst, synchronous) empties both stages and leaves the name as
// eleven spaces with the entry count at zero, same as a start transaction.
module fat_short_name_directory_lookup_top #(
  parameter int ROOT_ENTRIES = 224
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // path_char, entry_name_base, entry_name_ext, entry_attribute
  input  logic [1:0]   s_tuser,   // opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata,   // entry_index
  output logic [1:0]   m_tuser    // status
);
  import fdl_pkg::*;

  logic          s_acc;
  ctl_t          ctl;
  logic [7:0]    path_char;
  logic [63:0]   entry_name_base;
  logic [23:0]   entry_name_ext;
  logic [7:0]    entry_attribute;
  name_t         name;
  name_t         entry_name;
  logic [NAME_LEN-1:0] lane_eq;
  res_t          res;
  logic          skid_valid;
  logic [1:0]    skid_status;
  logic [7:0]    skid_index;

  // field unpacking
  assign path_char       = s_tdata[7:0];
  assign entry_name_base = s_tdata[71:8];
  assign entry_name_ext  = s_tdata[95:72];
  assign entry_attribute = s_tdata[103:96];
  assign entry_name      = {entry_name_ext, entry_name_base};

  // transaction decode
  assign s_tready = !skid_valid;
  assign s_acc    = s_tvalid && s_tready;

  always_comb begin
    ctl = '0;
    unique case (s_tuser)
      OP_START: ctl.start_op = s_acc;
      OP_CHAR:  ctl.char_op  = s_acc;
      OP_ENTRY: ctl.entry_op = s_acc;
      default:  ctl = '0;
    endcase
  end

  fdl_name_build u_name (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .path_char (path_char),
    .name      (name)
  );

  // compare lanes, one per name byte
  for (genvar k = 0; k < NAME_LEN; k++) begin : g_lane
    fdl_lane u_lane (
      .entry_byte (entry_name[k]),
      .name_byte  (name[k]),
      .equal      (lane_eq[k])
    );
  end

  fdl_merge #(
    .ROOT_ENTRIES (ROOT_ENTRIES)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .lane_eq    (lane_eq),
    .first_byte (entry_name[0]),
    .attribute  (entry_attribute),
    .res        (res)
  );

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        m_tuser    <= skid_status;
        m_tdata    <= skid_index;
        skid_valid <= 1'b0;
      end else if (res.valid) begin
        m_tvalid <= 1'b1;
        m_tuser  <= res.status;
        m_tdata  <= res.index;
      end else begin
        m_tvalid <= 1'b0;
      end
    end else if (res.valid) begin
      skid_valid  <= 1'b1;
      skid_status <= res.status;
      skid_index  <= res.index;
    end
  end

  `include "fat_short_name_directory_lookup_top_assert.svh"

  `FDL_ASSERT(a_skid_behind_out, !(skid_valid && !m_tvalid), "skid stage full with output empty")
  `FDL_ASSERT(a_entry_gives_result, ctl.entry_op && !m_tvalid |=> m_tvalid, "entry result lost")

endmodule
